/* src/slp_pkg.sv */
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, codes and defaults of the stepper limit positioner.
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int TGT_BITS     = 24;
  localparam int CFG_BITS     = 16;
  localparam int CFG_ADDR_W   = 1;
  localparam int IN_TDATA_W   = 32;

  localparam logic [CFG_BITS-1:0] SAFETY_BUFFER_RST = 16'd100;
  localparam logic [CFG_BITS-1:0] MAX_SEARCH_RST    = 16'd50000;

  localparam logic [CFG_ADDR_W-1:0] REG_SAFETY_BUFFER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SEARCH    = 1'b1;

  localparam logic [2:0] CMD_NOP     = 3'd0;
  localparam logic [2:0] CMD_CAL     = 3'd1;
  localparam logic [2:0] CMD_DEPLOY  = 3'd2;
  localparam logic [2:0] CMD_RETRACT = 3'd3;
  localparam logic [2:0] CMD_HOME    = 3'd4;
  localparam logic [2:0] CMD_MOVE    = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SEEK_RET = 3'd1,
    PH_SEEK_DEP = 3'd2,
    PH_MOVE     = 3'd3,
    PH_HOME     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_DONE      = 2'd1,
    ST_REJECT    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic    step_pulse;
    logic    direction;
    logic    busy;
    logic    calibrated;
    logic    save_request;
    status_t status;
  } slp_flags_t;

endpackage

/* src/slp_core.sv */
// ----------------------------------------------------------------------------
// slp_core
// Sequencer state and one-period update: switch searches, moves, calibration.
// ----------------------------------------------------------------------------
module slp_core
  import slp_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_en,
  input  logic [2:0]                      command,
  input  logic signed [TGT_BITS-1:0]      target,
  input  logic                            retracted_limit,
  input  logic                            deployed_limit,
  input  logic [CFG_BITS-1:0]             safety_buffer,
  input  logic [CFG_BITS-1:0]             max_search_steps,
  output slp_flags_t                      flags,
  output logic signed [POSITION_BITS-1:0] position,
  output logic signed [POSITION_BITS-1:0] deployed_end
);

  localparam int PW = POSITION_BITS;
  localparam logic signed [32:0] P_MAX = 33'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [32:0] P_MIN = -P_MAX - 33'sd1;

  // saturate a wide signed value into the position range
  function automatic logic signed [PW-1:0] sat_pos(input logic signed [32:0] v);
    logic signed [PW-1:0] r;
    if (v > P_MAX) r = P_MAX[PW-1:0];
    else if (v < P_MIN) r = P_MIN[PW-1:0];
    else r = v[PW-1:0];
    return r;
  endfunction

  // one step either way, clipped at the range ends
  function automatic logic signed [PW-1:0] step_pos(input logic signed [PW-1:0] p,
                                                    input logic fwd);
    logic signed [PW:0] s;
    logic signed [PW-1:0] r;
    s = fwd ? ({p[PW-1], p} + (PW+1)'(1)) : ({p[PW-1], p} - (PW+1)'(1));
    if (s[PW] != s[PW-1]) r = s[PW] ? P_MIN[PW-1:0] : P_MAX[PW-1:0];
    else r = s[PW-1:0];
    return r;
  endfunction

  // state
  phase_t                ph;
  logic [CFG_BITS-1:0]   srch;
  logic                  fwd;
  logic signed [PW-1:0]  pos;
  logic signed [PW-1:0]  lend;
  logic signed [PW-1:0]  send;
  logic                  cal;
  logic [PW-1:0]         left;

  phase_t                ph_next;
  logic [CFG_BITS-1:0]   srch_next;
  logic                  fwd_next;
  logic signed [PW-1:0]  pos_next;
  logic signed [PW-1:0]  lend_next;
  logic signed [PW-1:0]  send_next;
  logic                  cal_next;
  logic [PW-1:0]         left_next;
  logic                  step_c;
  logic                  save_c;
  status_t               stat_c;

  // move set up from idle: distance from the current position
  phase_t                ph_cur;
  logic signed [PW-1:0]  mv_tgt;
  logic signed [PW:0]    mv_d;
  logic signed [PW:0]    mv_abs;
  logic signed [PW-1:0]  srch_pos;

  assign ph_cur   = (ph > PH_HOME) ? PH_IDLE : ph;
  assign mv_tgt   = (command == CMD_DEPLOY)  ? send :
                    (command == CMD_RETRACT) ? '0 :
                    sat_pos(33'(target));
  assign mv_d     = {mv_tgt[PW-1], mv_tgt} - {pos[PW-1], pos};
  assign mv_abs   = mv_d[PW] ? -mv_d : mv_d;
  assign srch_pos = sat_pos(33'({1'b0, srch}));

  // next state
  always_comb begin
    ph_next   = ph_cur;
    srch_next = srch;
    fwd_next  = fwd;
    pos_next  = pos;
    lend_next = lend;
    send_next = send;
    cal_next  = cal;
    left_next = left;
    step_c    = 1'b0;
    save_c    = 1'b0;
    stat_c    = ST_NONE;

    if (ph_cur == PH_IDLE) begin
      case (command)
        CMD_CAL, CMD_HOME: begin
          ph_next   = (command == CMD_CAL) ? PH_SEEK_RET : PH_HOME;
          srch_next = '0;
          fwd_next  = 1'b0;
        end
        CMD_DEPLOY, CMD_RETRACT, CMD_MOVE: begin
          if (command != CMD_MOVE && !cal) begin
            stat_c = ST_REJECT;
          end else begin
            fwd_next  = !mv_d[PW] && (mv_d != '0);
            left_next = mv_abs[PW-1:0];
            ph_next   = PH_MOVE;
          end
        end
        default: ;
      endcase
    end

    case (ph_next)
      PH_SEEK_RET: begin
        fwd_next = 1'b0;
        if (retracted_limit || srch_next >= max_search_steps) begin
          pos_next  = '0;
          srch_next = '0;
          ph_next   = PH_SEEK_DEP;
        end else begin
          step_c    = 1'b1;
          srch_next = srch_next + 1'b1;
        end
      end
      PH_SEEK_DEP: begin
        if (deployed_limit || srch_next >= max_search_steps) begin
          // end learned; head back to zero, which is a backward move
          lend_next = srch_pos;
          pos_next  = srch_pos;
          send_next = sat_pos(33'(srch_pos) - 33'(safety_buffer));
          cal_next  = 1'b1;
          save_c    = 1'b1;
          fwd_next  = 1'b0;
          left_next = srch_pos;
          ph_next   = PH_MOVE;
        end else begin
          fwd_next  = 1'b1;
          step_c    = 1'b1;
          srch_next = srch_next + 1'b1;
          pos_next  = step_pos(pos, 1'b1);
        end
      end
      PH_MOVE: begin
        if (left_next == '0) begin
          ph_next = PH_IDLE;
          stat_c  = ST_DONE;
        end else if (fwd_next && deployed_limit) begin
          // early deployed hit relearns the end
          if (pos != lend) begin
            lend_next = pos;
            send_next = sat_pos(33'(pos) - 33'(safety_buffer));
            save_c    = 1'b1;
          end
          pos_next  = pos;
          left_next = '0;
          ph_next   = PH_IDLE;
          stat_c    = ST_DONE;
        end else if (!fwd_next && retracted_limit) begin
          pos_next  = '0;
          left_next = '0;
          ph_next   = PH_IDLE;
          stat_c    = ST_DONE;
        end else begin
          step_c    = 1'b1;
          left_next = left_next - 1'b1;
          pos_next  = step_pos(pos, fwd_next);
          if (left_next == '0) begin
            ph_next = PH_IDLE;
            stat_c  = ST_DONE;
          end
        end
      end
      PH_HOME: begin
        fwd_next = 1'b0;
        if (retracted_limit) begin
          pos_next = '0;
          ph_next  = PH_IDLE;
          stat_c   = ST_DONE;
        end else if (srch_next >= max_search_steps) begin
          ph_next = PH_IDLE;
          stat_c  = ST_NOT_FOUND;
        end else begin
          step_c    = 1'b1;
          srch_next = srch_next + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result of this period
  always_comb begin
    flags.step_pulse   = step_c;
    flags.direction    = fwd_next;
    flags.busy         = (ph_next != PH_IDLE);
    flags.calibrated   = cal_next;
    flags.save_request = save_c;
    flags.status       = stat_c;
    position           = pos_next;
    deployed_end       = lend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      srch <= '0;
      fwd  <= 1'b0;
      pos  <= '0;
      lend <= '0;
      send <= '0;
      cal  <= 1'b0;
      left <= '0;
    end else if (step_en) begin
      ph   <= ph_next;
      srch <= srch_next;
      fwd  <= fwd_next;
      pos  <= pos_next;
      lend <= lend_next;
      send <= send_next;
      cal  <= cal_next;
      left <= left_next;
    end
  end

endmodule

/* src/stepper_limit_positioner_top.sv */
// ----------------------------------------------------------------------------
// stepper_limit_positioner_top
// Stepper positioner with two limit switches, homing and travel calibration.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ channel is one step period: a command (calibrate,
//   deploy, retract, home, move) plus both limit switch levels. Each item
//   yields exactly one result item on m_ with the step pulse, direction,
//   position, busy, calibration info, save request and status.
//   Commands are only taken while idle; during a sequence they are ignored.
//   cfg_we/cfg_addr/cfg_wdata write safety_buffer (0) and max_search_steps (1);
//   write them only while no item is in flight.
// Pipeline / throughput:
//   Input register, then sequencer logic into the result register, which
//   raises m_tvalid once the item advances. One item per cycle sustained
//   while m_tready is high; the position update and phase logic are
//   combinational between the two registers.
// Reset (rst, synchronous): position, learned end, safe end cleared, not
//   calibrated, idle, both stages empty; buffer 100, search limit 50000.
// Stall: when m_tready is low the result holds; an empty input register can
//   still take one more item, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module stepper_limit_positioner_top
  import slp_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF,
  localparam int OUT_RAW = 2 * POSITION_BITS + 7,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // config
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  // items in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // command[2:0], target[26:3], retracted_limit[27], deployed_limit[28], zero pad
  input  logic [IN_TDATA_W-1:0] s_tdata,
  // results out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // step_pulse, direction, position, busy_res, is_calibrated, deployed_end,
  // save_request, status[1:0], zero pad (lowest bit first)
  output logic [OUT_W-1:0]      m_tdata
);

  localparam int PW      = POSITION_BITS;
  localparam int OUT_PAD = OUT_W - OUT_RAW;

  // config registers
  logic [CFG_BITS-1:0] safety_buffer;
  logic [CFG_BITS-1:0] max_search_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_buffer    <= SAFETY_BUFFER_RST;
      max_search_steps <= MAX_SEARCH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SAFETY_BUFFER: safety_buffer    <= cfg_wdata;
        REG_MAX_SEARCH:    max_search_steps <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic                       in_v;
  logic [2:0]                 in_cmd;
  logic signed [TGT_BITS-1:0] in_tgt;
  logic                       in_ret;
  logic                       in_dep;
  logic                       adv;

  // result register
  logic                 out_v;
  slp_flags_t           out_flags;
  logic signed [PW-1:0] out_pos;
  logic signed [PW-1:0] out_end;

  slp_flags_t           core_flags;
  logic signed [PW-1:0] core_pos;
  logic signed [PW-1:0] core_end;

  assign adv      = in_v && (!out_v || m_tready);
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tdata[2:0];
      in_tgt <= s_tdata[TGT_BITS+2:3];
      in_ret <= s_tdata[TGT_BITS+3];
      in_dep <= s_tdata[TGT_BITS+4];
    end
  end

  slp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .step_en          (adv),
    .command          (in_cmd),
    .target           (in_tgt),
    .retracted_limit  (in_ret),
    .deployed_limit   (in_dep),
    .safety_buffer    (safety_buffer),
    .max_search_steps (max_search_steps),
    .flags            (core_flags),
    .position         (core_pos),
    .deployed_end     (core_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags <= core_flags;
      out_pos   <= core_pos;
      out_end   <= core_end;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {{OUT_PAD{1'b0}}, out_flags.status, out_flags.save_request, out_end,
                     out_flags.calibrated, out_flags.busy, out_pos,
                     out_flags.direction, out_flags.step_pulse};

  // a save comes when the deployed search ends or a move stops at the deployed switch: no step then
  a_save_nostep: assert property (@(posedge clk) disable iff (rst)
    out_v && out_flags.save_request |-> !out_flags.step_pulse)
    else $error("save request together with a step");

  // any status report means the sequence is over
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    out_v && out_flags.status != ST_NONE |-> !out_flags.busy)
    else $error("status reported while still busy");

  // rejected or finished periods issue no step except the last step of a move
  a_reject_nostep: assert property (@(posedge clk) disable iff (rst)
    out_v && (out_flags.status == ST_REJECT || out_flags.status == ST_NOT_FOUND)
      |-> !out_flags.step_pulse)
    else $error("step issued with reject or not-found status");

  // no result is lost: a stalled result stays valid
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_v && !m_tready |=> out_v)
    else $error("result dropped while stalled");

endmodule
